// ===== hdl/sbcp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbcp_pkg
// Shared constants of the serial boot command parser: field widths and the
// command and response codes of the boot protocol.
// ----------------------------------------------------------------------------
package sbcp_pkg;

	// significant bits kept in the address and length accumulators
	localparam int ADDR_BITS = 32;
	localparam int LEN_BITS  = 32;

	// width of the address ports
	localparam int ADDR_PORT_W = 32;

	// received command codes
	localparam logic [7:0] CMD_RX_PING      = 8'd1;
	localparam logic [7:0] CMD_RX_LOAD_CODE = 8'd3;
	localparam logic [7:0] CMD_RX_EXECUTE   = 8'd5;
	localparam logic [7:0] CMD_RX_JUMP      = 8'd6;

	// transmitted response codes
	localparam logic [7:0] CMD_TX_PONG        = 8'd2;
	localparam logic [7:0] CMD_TX_CODE_LOADED = 8'd4;
	localparam logic [7:0] CMD_TX_RUNNING     = 8'd7;

	// number of bytes in a length or address field
	localparam int FIELD_BYTES = 4;

endpackage

// ===== hdl/serial_boot_command_parser.sv =====
// ----------------------------------------------------------------------------
// serial_boot_command_parser
// Parses the received byte stream of a serial boot loader and produces one
// result per byte: memory write, response byte, call/jump request, idle flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: rx_byte with in_valid / in_stall. A byte is transferred at
//   a rising edge with in_valid high and in_stall low.
//   Output channel: all result fields with out_valid / out_stall; every
//   received byte yields exactly one result transfer, in order.
//   Path: a taken byte is held in the input register and then passes on to the
//   result register, which presents its result.
//   Throughput: one byte per cycle while no result is stalled; the parser state
//   (phase, byte counter, length and address accumulators) is updated in the
//   same cycle as the result register, so back-to-back bytes need no bubbles.
//   Stall: while out_stall holds a presented result, the result register and
//   the input register hold; in_stall rises only when the input register is
//   full and cannot move on. A result stays stable until transferred.
//   Reset: arst_n low clears both registers' valid flags and returns the
//   parser to idle with cleared counters and accumulators.
// ----------------------------------------------------------------------------
module serial_boot_command_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	// received bytes
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	// results
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             write_valid,
	output logic [sbcp_pkg::ADDR_PORT_W-1:0] write_addr,
	output logic [7:0]                       write_data,
	output logic                             tx_valid,
	output logic [7:0]                       tx_byte,
	output logic                             jump_valid,
	output logic [sbcp_pkg::ADDR_PORT_W-1:0] jump_addr,
	output logic                             jump_is_call,
	output logic                             ready_led
);

	localparam int AW = sbcp_pkg::ADDR_BITS;
	localparam int LW = sbcp_pkg::LEN_BITS;
	localparam int PW = sbcp_pkg::ADDR_PORT_W;
	localparam logic [1:0] LAST_BYTE = 2'(sbcp_pkg::FIELD_BYTES - 1);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEN    = 3'd1,
		PH_ADDR   = 3'd2,
		PH_DATA   = 3'd3,
		PH_TARGET = 3'd4
	} phase_t;

	typedef struct packed {
		logic          write_valid;
		logic [PW-1:0] write_addr;
		logic [7:0]    write_data;
		logic          tx_valid;
		logic [7:0]    tx_byte;
		logic          jump_valid;
		logic [PW-1:0] jump_addr;
		logic          jump_is_call;
		logic          ready_led;
	} result_t;

	// parser state
	phase_t        phase_q;
	logic [1:0]    byte_cnt_q;
	logic [LW-1:0] rem_len_q;
	logic [AW-1:0] addr_acc_q;
	logic          call_q;

	// pipeline registers
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          valid_s2;
	result_t       res_s2;

	// next-state and result logic
	phase_t        phase_d;
	logic [1:0]    byte_cnt_d;
	logic [LW-1:0] rem_len_d;
	logic [AW-1:0] addr_acc_d;
	logic          call_d;
	result_t       res_d;
	logic          last;
	logic [LW+7:0] len_shift;
	logic [AW+7:0] addr_shift;
	logic [LW-1:0] len_dec;

	// handshake control
	logic advance;
	logic take_s1;
	logic load_s1;

	assign advance  = !valid_s2 || !out_stall;
	assign take_s1  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	// field accumulators and byte counting
	assign last       = (byte_cnt_q == LAST_BYTE);
	assign len_shift  = {rem_len_q, byte_s1};
	assign addr_shift = {addr_acc_q, byte_s1};
	assign len_dec    = rem_len_q - LW'(1);

	// per-byte parser step
	always_comb begin
		phase_d    = phase_q;
		byte_cnt_d = byte_cnt_q;
		rem_len_d  = rem_len_q;
		addr_acc_d = addr_acc_q;
		call_d     = call_q;
		res_d      = '0;
		case (phase_q)
			PH_LEN: begin
				rem_len_d  = len_shift[LW-1:0];
				byte_cnt_d = byte_cnt_q + 2'd1;
				if (last) begin
					phase_d = PH_ADDR;
				end
			end
			PH_ADDR: begin
				addr_acc_d = addr_shift[AW-1:0];
				byte_cnt_d = byte_cnt_q + 2'd1;
				if (last) begin
					if (rem_len_q == '0) begin
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = sbcp_pkg::CMD_TX_CODE_LOADED;
						phase_d        = PH_IDLE;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				res_d.write_valid = 1'b1;
				res_d.write_addr  = PW'(addr_acc_q);
				res_d.write_data  = byte_s1;
				addr_acc_d        = addr_acc_q + AW'(1);
				rem_len_d         = len_dec;
				if (len_dec == '0) begin
					res_d.tx_valid = 1'b1;
					res_d.tx_byte  = sbcp_pkg::CMD_TX_CODE_LOADED;
					phase_d        = PH_IDLE;
				end
			end
			PH_TARGET: begin
				addr_acc_d = addr_shift[AW-1:0];
				byte_cnt_d = byte_cnt_q + 2'd1;
				if (last) begin
					res_d.tx_valid     = 1'b1;
					res_d.tx_byte      = sbcp_pkg::CMD_TX_RUNNING;
					res_d.jump_valid   = 1'b1;
					res_d.jump_addr    = PW'(addr_shift[AW-1:0]);
					res_d.jump_is_call = call_q;
					phase_d            = PH_IDLE;
				end
			end
			default: begin
				// idle and unused codes: decode a command byte
				phase_d = PH_IDLE;
				if (byte_s1 == sbcp_pkg::CMD_RX_PING) begin
					res_d.tx_valid = 1'b1;
					res_d.tx_byte  = sbcp_pkg::CMD_TX_PONG;
				end else if (byte_s1 == sbcp_pkg::CMD_RX_LOAD_CODE) begin
					byte_cnt_d = '0;
					rem_len_d  = '0;
					addr_acc_d = '0;
					phase_d    = PH_LEN;
				end else if (byte_s1 == sbcp_pkg::CMD_RX_EXECUTE ||
					     byte_s1 == sbcp_pkg::CMD_RX_JUMP) begin
					byte_cnt_d = '0;
					rem_len_d  = '0;
					addr_acc_d = '0;
					phase_d    = PH_TARGET;
					call_d     = (byte_s1 == sbcp_pkg::CMD_RX_EXECUTE);
				end
			end
		endcase
		res_d.ready_led = (phase_d == PH_IDLE);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser state, updated as a byte moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			byte_cnt_q <= '0;
			rem_len_q  <= '0;
			addr_acc_q <= '0;
			call_q     <= 1'b0;
		end else if (take_s1) begin
			phase_q    <= phase_d;
			byte_cnt_q <= byte_cnt_d;
			rem_len_q  <= rem_len_d;
			addr_acc_q <= addr_acc_d;
			call_q     <= call_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			res_s2 <= res_d;
		end
	end

	// output ports
	assign out_valid    = valid_s2;
	assign write_valid  = res_s2.write_valid;
	assign write_addr   = res_s2.write_addr;
	assign write_data   = res_s2.write_data;
	assign tx_valid     = res_s2.tx_valid;
	assign tx_byte      = res_s2.tx_byte;
	assign jump_valid   = res_s2.jump_valid;
	assign jump_addr    = res_s2.jump_addr;
	assign jump_is_call = res_s2.jump_is_call;
	assign ready_led    = res_s2.ready_led;

	// a call or jump request always goes with the running response
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && jump_valid) |->
		(tx_valid && tx_byte == sbcp_pkg::CMD_TX_RUNNING && ready_led))
	else $error("jump request without running response");

	// a memory write and a jump never share one result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(write_valid && jump_valid))
	else $error("write and jump in the same result");

	// the byte counter only runs while a multi-byte field is being read
	assert property (@(posedge clk) disable iff (!arst_n)
		(byte_cnt_q != 2'd0) |->
		(phase_q == PH_LEN || phase_q == PH_ADDR || phase_q == PH_TARGET))
	else $error("byte counter active outside a field phase");

	// data phase is only entered with a nonzero length
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (rem_len_q != '0))
	else $error("data phase with zero remaining length");

	// parser state moves only with a transfer into the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!take_s1 |=> ($stable(phase_q) && $stable(addr_acc_q) && $stable(rem_len_q)))
	else $error("parser state changed without a byte");

endmodule
